// ===== rtl/core/spectrum_bin_average_quantizer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, disabled while arst_n is low. Compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BIN_AVERAGE_QUANTIZER_CORE_MACROS_SVH
`define SPECTRUM_BIN_AVERAGE_QUANTIZER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SBAQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sbaq: property failed");
`define SBAQ_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("sbaq: forbidden condition seen");
`else
`define SBAQ_ASSERT(lbl, prop)
`define SBAQ_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/core/sbaq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbaq_pkg
// Shared constants, types and codes of the bin averaging quantizer.
// ----------------------------------------------------------------------------
package sbaq_pkg;

	localparam int unsigned MAX_IN_BINS  = 4096;
	localparam int unsigned MAX_OUT_BINS = 64;

	localparam int unsigned IN_BINS_W  = 13;
	localparam int unsigned OUT_BINS_W = 7;
	localparam int unsigned POS_W      = $clog2(MAX_IN_BINS);
	localparam int unsigned BIN_W      = $clog2(MAX_OUT_BINS);
	localparam int unsigned MAG_W      = 18;
	localparam int unsigned SUM_W      = 31;
	localparam int unsigned CNT_W      = 13;
	localparam int unsigned PROD_W     = $clog2(MAX_IN_BINS * MAX_OUT_BINS) + 1;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned SCALE_SHIFT = 15;
	localparam int unsigned FULL_W     = CNT_W + SCALE_SHIFT;
	localparam int unsigned SCALED_W   = FULL_W + LEVEL_W - SCALE_SHIFT;
	localparam int unsigned DIV_STEP_W = $clog2(LEVEL_W);

	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 13;
	localparam int unsigned RESET_BINS  = 64;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_INPUT_BINS  = 1'b0,
		CFG_OUTPUT_BINS = 1'b1
	} cfg_index_t;

	typedef enum logic {
		ENTRY_LEVEL = 1'b0,
		ENTRY_PAD   = 1'b1
	} entry_kind_t;

	// one unit of back-end work: a level to quantise, or a run of zero bins
	typedef struct packed {
		entry_kind_t              kind;
		logic signed [SUM_W-1:0]  sum;
		logic [CNT_W-1:0]         count;
		logic [BIN_W-1:0]         bin;
		logic [BIN_W-1:0]         end_bin;
		logic                     last;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCALE,
		BK_DIV,
		BK_EMIT,
		BK_PAD
	} back_state_t;

endpackage

// ===== rtl/core/sbaq_front.sv =====
// ----------------------------------------------------------------------------
// sbaq_front
// Configuration registers, frame tracking and bin accumulation. Each beat is
// classified against exact integer bin bounds and any finished work is queued.
// ----------------------------------------------------------------------------
`include "spectrum_bin_average_quantizer_core_macros.svh"

module sbaq_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [sbaq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [sbaq_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  push,
	input  logic signed [sbaq_pkg::MAG_W-1:0]     magnitude,
	output logic                                  full,
	output logic                                  q_push,
	output sbaq_pkg::work_t                       q_work,
	input  sbaq_pkg::q_status_t                   q_status
);

	localparam int unsigned INW  = sbaq_pkg::IN_BINS_W;
	localparam int unsigned OUTW = sbaq_pkg::OUT_BINS_W;
	localparam int unsigned SW   = sbaq_pkg::SUM_W;
	localparam int unsigned CW   = sbaq_pkg::CNT_W;
	localparam int unsigned PW   = sbaq_pkg::PROD_W;
	localparam int unsigned BW   = sbaq_pkg::BIN_W;

	logic [INW-1:0]              in_bins_q;
	logic [OUTW-1:0]             out_bins_q;
	logic [sbaq_pkg::POS_W-1:0]  in_pos_q;
	logic [BW-1:0]               out_pos_q;
	logic signed [SW-1:0]        sum_cur_q, sum_fol_q;
	logic [CW-1:0]               cnt_cur_q, cnt_fol_q;
	logic [PW-1:0]               jm_q, bnd_q;
	logic                        res_pend_q, pad_pend_q;
	sbaq_pkg::work_t             res_work_q, pad_work_q;

	logic [INW-1:0]              n_eff, m_ext, j_ext;
	logic [OUTW-1:0]             m_eff, i_ext, m_m1;
	logic                        restart, avg, last_in, i_more, follow, is_end, acc;
	logic [sbaq_pkg::POS_W-1:0]  j;
	logic [BW-1:0]               i;
	logic signed [SW-1:0]        sc, sf, x_ext, sum_new, fol_sum;
	logic [CW-1:0]               cc, cf, cnt_new, fol_cnt;
	logic [PW-1:0]               jm, bnd, b_next, jm_hi;

	logic [sbaq_pkg::POS_W-1:0]  nxt_in_pos;
	logic [BW-1:0]               nxt_out_pos;
	logic signed [SW-1:0]        nxt_sum_cur, nxt_sum_fol;
	logic [CW-1:0]               nxt_cnt_cur, nxt_cnt_fol;
	logic [PW-1:0]               nxt_jm, nxt_bnd;
	logic                        res_emit, pad_emit;
	sbaq_pkg::work_t             res_work, pad_work;

	// clamped register views
	always_comb begin
		if (in_bins_q == '0) begin
			n_eff = INW'(1);
		end else if (in_bins_q > INW'(sbaq_pkg::MAX_IN_BINS)) begin
			n_eff = INW'(sbaq_pkg::MAX_IN_BINS);
		end else begin
			n_eff = in_bins_q;
		end
		if (out_bins_q == '0) begin
			m_eff = OUTW'(1);
		end else if (out_bins_q > OUTW'(sbaq_pkg::MAX_OUT_BINS)) begin
			m_eff = OUTW'(sbaq_pkg::MAX_OUT_BINS);
		end else begin
			m_eff = out_bins_q;
		end
	end

	assign m_ext = INW'(m_eff);
	assign m_m1  = m_eff - OUTW'(1);
	assign avg   = n_eff > m_ext;

	assign restart = (INW'(in_pos_q) >= n_eff) || (OUTW'(out_pos_q) >= m_eff);
	assign j   = restart ? '0 : in_pos_q;
	assign i   = restart ? '0 : out_pos_q;
	assign sc  = restart ? '0 : sum_cur_q;
	assign sf  = restart ? '0 : sum_fol_q;
	assign cc  = restart ? '0 : cnt_cur_q;
	assign cf  = restart ? '0 : cnt_fol_q;
	assign jm  = restart ? '0 : jm_q;
	assign bnd = restart ? '0 : bnd_q;

	assign j_ext   = INW'(j);
	assign i_ext   = OUTW'(i);
	assign last_in = j_ext == (n_eff - INW'(1));
	assign x_ext   = {{(SW - sbaq_pkg::MAG_W){magnitude[sbaq_pkg::MAG_W-1]}}, magnitude};

	// j*m against (i+1)*n gives floor and ceil of the bound without a divider
	assign b_next  = bnd + PW'(n_eff);
	assign jm_hi   = jm + PW'(m_eff);
	assign i_more  = (i_ext + OUTW'(1)) < m_eff;
	assign follow  = i_more && (jm <= b_next) && (b_next < jm_hi);
	assign is_end  = (jm < b_next) && (b_next <= jm_hi);
	assign sum_new = sc + x_ext;
	assign cnt_new = cc + CW'(1);
	assign fol_sum = follow ? (sf + x_ext) : sf;
	assign fol_cnt = follow ? (cf + CW'(1)) : cf;

	always_comb begin
		nxt_in_pos  = j + sbaq_pkg::POS_W'(1);
		nxt_out_pos = i;
		nxt_sum_cur = sc;
		nxt_cnt_cur = cc;
		nxt_sum_fol = sf;
		nxt_cnt_fol = cf;
		nxt_jm      = jm;
		nxt_bnd     = bnd;
		res_emit    = 1'b0;
		pad_emit    = 1'b0;
		res_work    = '0;
		pad_work    = '0;
		if (!avg) begin
			res_emit       = 1'b1;
			res_work.kind  = sbaq_pkg::ENTRY_LEVEL;
			res_work.sum   = x_ext;
			res_work.count = CW'(1);
			res_work.bin   = j[BW-1:0];
			res_work.last  = j_ext == (m_ext - INW'(1));
			pad_emit         = last_in && (n_eff < m_ext);
			pad_work.kind    = sbaq_pkg::ENTRY_PAD;
			pad_work.bin     = n_eff[BW-1:0];
			pad_work.end_bin = m_m1[BW-1:0];
			pad_work.last    = 1'b1;
		end else begin
			nxt_sum_cur = sum_new;
			nxt_cnt_cur = cnt_new;
			nxt_sum_fol = fol_sum;
			nxt_cnt_fol = fol_cnt;
			nxt_jm      = jm_hi;
			if (is_end) begin
				res_emit       = 1'b1;
				res_work.kind  = sbaq_pkg::ENTRY_LEVEL;
				res_work.sum   = sum_new;
				res_work.count = cnt_new;
				res_work.bin   = i;
				res_work.last  = i_ext == m_m1;
				nxt_sum_cur    = fol_sum;
				nxt_cnt_cur    = fol_cnt;
				nxt_sum_fol    = '0;
				nxt_cnt_fol    = '0;
				nxt_out_pos    = i + BW'(1);
				nxt_bnd        = b_next;
			end
		end
	end

	assign full   = res_pend_q || pad_pend_q;
	assign acc    = push && !full;
	assign q_push = full && !q_status.full;
	assign q_work = res_pend_q ? res_work_q : pad_work_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bins_q  <= INW'(sbaq_pkg::RESET_BINS);
			out_bins_q <= OUTW'(sbaq_pkg::RESET_BINS);
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			sum_cur_q  <= '0;
			cnt_cur_q  <= '0;
			sum_fol_q  <= '0;
			cnt_fol_q  <= '0;
			jm_q       <= '0;
			bnd_q      <= '0;
			res_pend_q <= 1'b0;
			pad_pend_q <= 1'b0;
		end else begin
			if (q_push) begin
				if (res_pend_q) begin
					res_pend_q <= 1'b0;
				end else begin
					pad_pend_q <= 1'b0;
				end
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					sbaq_pkg::CFG_INPUT_BINS:  in_bins_q  <= cfg_data;
					sbaq_pkg::CFG_OUTPUT_BINS: out_bins_q <= cfg_data[OUTW-1:0];
					default: ;
				endcase
				in_pos_q  <= '0;
				out_pos_q <= '0;
				sum_cur_q <= '0;
				cnt_cur_q <= '0;
				sum_fol_q <= '0;
				cnt_fol_q <= '0;
				jm_q      <= '0;
				bnd_q     <= '0;
			end else if (acc) begin
				res_pend_q <= res_emit;
				pad_pend_q <= pad_emit;
				if (last_in) begin
					in_pos_q  <= '0;
					out_pos_q <= '0;
					sum_cur_q <= '0;
					cnt_cur_q <= '0;
					sum_fol_q <= '0;
					cnt_fol_q <= '0;
					jm_q      <= '0;
					bnd_q     <= '0;
				end else begin
					in_pos_q  <= nxt_in_pos;
					out_pos_q <= nxt_out_pos;
					sum_cur_q <= nxt_sum_cur;
					cnt_cur_q <= nxt_cnt_cur;
					sum_fol_q <= nxt_sum_fol;
					cnt_fol_q <= nxt_cnt_fol;
					jm_q      <= nxt_jm;
					bnd_q     <= nxt_bnd;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_work_q <= res_work;
			pad_work_q <= pad_work;
		end
	end

	`SBAQ_ASSERT(a_in_pos_in_frame, !restart)
	`SBAQ_ASSERT(a_pad_follows_level, (acc && pad_emit) |=> res_pend_q)

endmodule

// ===== rtl/core/sbaq_queue.sv =====
// ----------------------------------------------------------------------------
// sbaq_queue
// Short first-in first-out buffer of work entries between front and back.
// ----------------------------------------------------------------------------
`include "spectrum_bin_average_quantizer_core_macros.svh"

module sbaq_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  sbaq_pkg::work_t      wr_work,
	input  logic                 pop,
	output sbaq_pkg::work_t      rd_work,
	output sbaq_pkg::q_status_t  status
);

	localparam int unsigned PTW = sbaq_pkg::FIFO_PTR_W;

	sbaq_pkg::work_t  mem_q [sbaq_pkg::FIFO_DEPTH];
	logic [PTW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTW:0]     count_q;
	logic             do_push, do_pop;

	assign status.full  = count_q == (PTW + 1)'(sbaq_pkg::FIFO_DEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign rd_work      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_work;
		end
	end

	`SBAQ_ASSERT_NEVER(a_no_overflow, push && status.full)
	`SBAQ_ASSERT(a_ptr_gap, (wr_ptr_q - rd_ptr_q) == count_q[PTW-1:0])

endmodule

// ===== rtl/core/sbaq_back.sv =====
// ----------------------------------------------------------------------------
// sbaq_back
// Scales a clamped bin sum to 255 full scale and divides by the bin count,
// one quotient bit per cycle; expands zero runs; holds the result register.
// ----------------------------------------------------------------------------
`include "spectrum_bin_average_quantizer_core_macros.svh"

module sbaq_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sbaq_pkg::q_status_t                q_status,
	input  sbaq_pkg::work_t                    q_work,
	output logic                               q_pop,
	output logic                               empty,
	input  logic                               pop,
	output logic [sbaq_pkg::LEVEL_W-1:0]       level,
	output logic [sbaq_pkg::BIN_W-1:0]         bin_index,
	output logic                               last
);

	localparam int unsigned SW  = sbaq_pkg::SUM_W;
	localparam int unsigned FW  = sbaq_pkg::FULL_W;
	localparam int unsigned LW  = sbaq_pkg::LEVEL_W;
	localparam int unsigned TW  = sbaq_pkg::SCALED_W;
	localparam int unsigned DSW = sbaq_pkg::DIV_STEP_W;
	localparam int unsigned BW  = sbaq_pkg::BIN_W;

	sbaq_pkg::back_state_t  state_q, state_d;
	sbaq_pkg::work_t        work_q;
	logic [TW-1:0]          rem_q;
	logic [DSW-1:0]         step_q;
	logic [LW-1:0]          quo_q;
	logic [BW-1:0]          pad_bin_q;
	logic                   out_valid_q;
	logic [LW-1:0]          level_q;
	logic [BW-1:0]          bin_q;
	logic                   last_q;

	logic [FW-1:0]          full_scale, clipped;
	logic [SW-2:0]          sum_mag;
	logic                   sum_pos;
	logic [FW+LW-1:0]       prod;
	logic [TW-1:0]          scaled, div_sh;
	logic [TW:0]            rem_bound;
	logic                   out_free, out_load, out_last, pad_done;
	logic [LW-1:0]          out_level;
	logic [BW-1:0]          out_bin;

	// clamp to [0, count*32768], then floor(s*255 / 32768)
	assign full_scale = {work_q.count, {sbaq_pkg::SCALE_SHIFT{1'b0}}};
	assign sum_pos    = !work_q.sum[SW-1] && (work_q.sum != '0);
	assign sum_mag    = work_q.sum[SW-2:0];
	assign clipped    = !sum_pos ? '0 :
		(sum_mag > (SW - 1)'(full_scale)) ? full_scale : sum_mag[FW-1:0];
	assign prod       = {clipped, {LW{1'b0}}} - (FW + LW)'(clipped);
	assign scaled     = prod[FW+LW-1:sbaq_pkg::SCALE_SHIFT];
	assign div_sh     = TW'(work_q.count) << step_q;
	assign rem_bound  = (TW + 1)'(work_q.count) << ((DSW + 1)'(step_q) + (DSW + 1)'(1));

	assign out_free = !out_valid_q || pop;
	assign pad_done = pad_bin_q == work_q.end_bin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbaq_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		out_load  = 1'b0;
		out_level = '0;
		out_bin   = '0;
		out_last  = 1'b0;
		unique case (state_q)
			sbaq_pkg::BK_IDLE: begin
				if (!q_status.empty) begin
					q_pop   = 1'b1;
					state_d = (q_work.kind == sbaq_pkg::ENTRY_PAD) ?
						sbaq_pkg::BK_PAD : sbaq_pkg::BK_SCALE;
				end
			end
			sbaq_pkg::BK_SCALE: begin
				state_d = sbaq_pkg::BK_DIV;
			end
			sbaq_pkg::BK_DIV: begin
				if (step_q == '0) begin
					state_d = sbaq_pkg::BK_EMIT;
				end
			end
			sbaq_pkg::BK_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_level = quo_q;
					out_bin   = work_q.bin;
					out_last  = work_q.last;
					state_d   = sbaq_pkg::BK_IDLE;
				end
			end
			sbaq_pkg::BK_PAD: begin
				if (out_free) begin
					out_load = 1'b1;
					out_bin  = pad_bin_q;
					out_last = pad_done;
					if (pad_done) begin
						state_d = sbaq_pkg::BK_IDLE;
					end
				end
			end
			default: begin
				state_d = sbaq_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q    <= q_work;
			pad_bin_q <= q_work.bin;
		end
		if (state_q == sbaq_pkg::BK_SCALE) begin
			rem_q  <= scaled;
			step_q <= DSW'(LW - 1);
			quo_q  <= '0;
		end
		if (state_q == sbaq_pkg::BK_DIV) begin
			if (rem_q >= div_sh) begin
				rem_q         <= rem_q - div_sh;
				quo_q[step_q] <= 1'b1;
			end
			step_q <= step_q - DSW'(1);
		end
		if (state_q == sbaq_pkg::BK_PAD && out_free && !pad_done) begin
			pad_bin_q <= pad_bin_q + BW'(1);
		end
		if (out_load) begin
			level_q <= out_level;
			bin_q   <= out_bin;
			last_q  <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty     = !out_valid_q;
	assign level     = level_q;
	assign bin_index = bin_q;
	assign last      = last_q;

	`SBAQ_ASSERT(a_div_rem_bound, (state_q == sbaq_pkg::BK_DIV) |-> (TW + 1)'(rem_q) < rem_bound)
	`SBAQ_ASSERT(a_pad_in_range, (state_q == sbaq_pkg::BK_PAD) |-> pad_bin_q <= work_q.end_bin)

endmodule

// ===== rtl/core/spectrum_bin_average_quantizer_core.sv =====
// ----------------------------------------------------------------------------
// spectrum_bin_average_quantizer_core
// Path: a beat that closes a bin is held pending and queued; the back end then
// scales it, divides it (8 divider steps) and emits it to the result register.
// Beats that close no bin are taken back to back; one that closes a bin, or
// also queues zero bins, holds full until its entries are queued.
// Reset: 64 input and 64 output bins, frame cleared, queue and result empty.
// ----------------------------------------------------------------------------
module spectrum_bin_average_quantizer_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sbaq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [sbaq_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                  push,
	output logic                                  full,
	input  logic signed [sbaq_pkg::MAG_W-1:0]     magnitude,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [sbaq_pkg::LEVEL_W-1:0]          level,
	output logic [sbaq_pkg::BIN_W-1:0]            bin_index,
	output logic                                  last
);

	logic                 q_push, q_pop;
	sbaq_pkg::work_t      q_wr_work, q_rd_work;
	sbaq_pkg::q_status_t  q_status;

	assign cfg_ready = 1'b1;

	sbaq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.magnitude (magnitude),
		.full      (full),
		.q_push    (q_push),
		.q_work    (q_wr_work),
		.q_status  (q_status)
	);

	sbaq_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_work (q_wr_work),
		.pop     (q_pop),
		.rd_work (q_rd_work),
		.status  (q_status)
	);

	sbaq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.q_work    (q_rd_work),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.level     (level),
		.bin_index (bin_index),
		.last      (last)
	);

endmodule
